// ===== hw/rtl/epid_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package epid_pkg;

	// encoder geometry
	localparam int ENC_COUNTS    = 16384;
	localparam int ENC_HALF      = ENC_COUNTS / 2;
	localparam int ENC_SHIFT     = $clog2(ENC_COUNTS);
	localparam int TARGET_RESET  = ENC_COUNTS / 2;
	localparam int TARGET_PRESET = ENC_COUNTS / 8;

	// field widths
	localparam int RAW_W    = 14;
	localparam int MV_W     = 16;
	localparam int GAIN_W   = 16;
	localparam int CNT_W    = 32;
	localparam int TGT_W    = 16;
	localparam int VOLT_W   = 16;
	localparam int IN_W     = 48;
	localparam int OUT_W    = 96;
	localparam int CFG_IDX_W = 2;

	// input request layout, lowest bit first
	localparam int IN_MRAW_LSB  = 0;
	localparam int IN_SRAW_LSB  = IN_MRAW_LSB + RAW_W;
	localparam int IN_MV_LSB    = IN_SRAW_LSB + RAW_W;
	localparam int IN_ZERO_BIT  = IN_MV_LSB + MV_W;
	localparam int IN_PLUS_BIT  = IN_ZERO_BIT + 1;
	localparam int IN_MINUS_BIT = IN_PLUS_BIT + 1;
	localparam int IN_EN_BIT    = IN_MINUS_BIT + 1;

	// loop arithmetic widths, angles in quarter counts
	localparam int ANG_W  = 35;
	localparam int SPD_W  = ANG_W + 1;
	localparam int INT_W  = 48;
	localparam int HALF_W = INT_W / 2;
	localparam int PROD_W = GAIN_W + HALF_W + 2;
	localparam int MAC_W  = 66;

	// integral clamp scaling
	localparam int LIM_SHIFT = ENC_SHIFT + 2;
	localparam int SET_SHIFT = ENC_SHIFT - 6;

	// drive scaling and limit
	localparam int VOLT_SCALE = 20;
	localparam int VOLT_MAX   = 20480;

	// battery filter
	localparam int BATT_W      = 32;
	localparam int BATT_NUM_W  = 40;
	localparam int BATT_POLE   = 99;
	localparam int BATT_DEN    = 100;
	localparam int BATT_RND    = 50;
	localparam int BATT_FRAC   = 16;
	localparam logic [BATT_W-1:0] BATT_RESET = BATT_W'(24000) << BATT_FRAC;

	// configuration registers
	localparam logic [GAIN_W-1:0] PROP_RESET  = 16'd5120;
	localparam logic [GAIN_W-1:0] DERIV_RESET = 16'd10240;
	localparam logic [GAIN_W-1:0] INTEG_RESET = 16'd0;
	localparam logic [GAIN_W-1:0] LIMIT_RESET = 16'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN   = 2'd0,
		REG_DERIV_GAIN  = 2'd1,
		REG_INTEG_GAIN  = 2'd2,
		REG_INTEG_LIMIT = 2'd3
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DELTA,
		ST_ACC,
		ST_ANGLE,
		ST_ERR,
		ST_INTEG,
		ST_KI_LO,
		ST_KI_HI,
		ST_CLAMP,
		ST_KD_LO,
		ST_KD_HI,
		ST_KI2_LO,
		ST_KI2_HI,
		ST_KP_LO,
		ST_KP_HI,
		ST_SCALE,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		MOP_INTEG,
		MOP_SPEED,
		MOP_ERR
	} mac_op_t;

	typedef struct packed {
		logic en;
		logic clear;
		logic hi;
	} mac_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/encoder_pid_position_loop.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Position loop for a geared drive with two absolute encoders. Each request on
// the s_ side is one control tick: both encoder readings are unwrapped and
// accumulated, a PID with derivative on measurement runs on the motor angle
// against the preset target times 36/16 with a clamped integral, and the
// battery sample is smoothed by a 0.99/0.01 filter. One result leaves on the
// m_ side per tick. A tick holds the block from acceptance until its result is
// loaded: a small sequencer runs eight passes through one shared 17x25-bit
// multiply-accumulate unit, while the battery division by 100 runs alongside.
// s_tready is high only between ticks; a finished result waits in the output
// register, so the next tick may be accepted before it is taken.
// Configuration writes belong in idle periods; an index has four registers:
// proportional gain, derivative gain, integral gain, integral limit.
module encoder_pid_position_loop (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// motor_raw, steer_raw, battery_mv, zero_counts, preset_plus, preset_minus,
	// enable
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [epid_pkg::IN_W-1:0]            s_tdata,
	// drive_voltage, battery_filtered_mv, motor_count, steer_count
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [epid_pkg::OUT_W-1:0]           m_tdata,
	input  logic                                 cfg_wen,
	input  logic [epid_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [epid_pkg::GAIN_W-1:0]          cfg_wdata
);

	localparam int UNW_W = epid_pkg::RAW_W + 2;

	function automatic logic signed [UNW_W-1:0] unwrap(
		input logic [epid_pkg::RAW_W-1:0] prv,
		input logic [epid_pkg::RAW_W-1:0] now
	);
		logic signed [UNW_W-1:0] d;
		d = $signed(UNW_W'(prv)) - $signed(UNW_W'(now));
		if (d > $signed(UNW_W'(epid_pkg::ENC_HALF))) begin
			d = d - $signed(UNW_W'(epid_pkg::ENC_COUNTS));
		end else if (d < -$signed(UNW_W'(epid_pkg::ENC_HALF))) begin
			d = d + $signed(UNW_W'(epid_pkg::ENC_COUNTS));
		end
		return d;
	endfunction

	epid_pkg::state_t state_q, state_d;

	// configuration
	logic [epid_pkg::GAIN_W-1:0] kp_q, kd_q, ki_q, lim_q;

	// loop state
	logic [epid_pkg::RAW_W-1:0]         prev_mraw_q, prev_sraw_q;
	logic [epid_pkg::CNT_W-1:0]         macc_q, sacc_q;
	logic signed [epid_pkg::TGT_W-1:0]  target_q;
	logic signed [epid_pkg::ANG_W-1:0]  prev_angle_q;
	logic signed [epid_pkg::INT_W-1:0]  integ_q;
	logic [epid_pkg::BATT_W-1:0]        batt_q;

	// captured request and working values
	logic [epid_pkg::RAW_W-1:0]         mraw_q, sraw_q;
	logic [epid_pkg::MV_W-1:0]          mv_q;
	logic                               zero_q, plus_q, minus_q, en_q;
	logic signed [UNW_W-1:0]            dm_q, ds_q;
	logic signed [epid_pkg::ANG_W-1:0]  angle_q, err_q;
	logic signed [epid_pkg::SPD_W-1:0]  speed_q;
	logic signed [epid_pkg::MAC_W-1:0]  scaled_q;

	// output register
	logic                               out_valid_q;
	logic [epid_pkg::OUT_W-1:0]         out_data_q;

	// sequencer outputs
	epid_pkg::mac_ctrl_t                mac_ctrl;
	epid_pkg::mac_op_t                  mac_op;
	logic                               div_start;
	logic                               out_load;

	// shared unit signals
	logic [epid_pkg::GAIN_W-1:0]        mac_gain;
	logic signed [epid_pkg::INT_W-1:0]  mac_opnd;
	logic signed [epid_pkg::MAC_W-1:0]  mac_acc;
	logic                               div_busy;
	logic [epid_pkg::BATT_W-1:0]        div_quot;
	logic [epid_pkg::BATT_NUM_W-1:0]    batt_numer;

	// datapath helpers
	logic                               in_req;
	logic signed [epid_pkg::ANG_W-1:0]  angle_d;
	logic signed [epid_pkg::ANG_W-1:0]  target9;
	logic signed [epid_pkg::INT_W:0]    integ_sum;
	logic signed [epid_pkg::INT_W-1:0]  integ_sat;
	logic signed [epid_pkg::MAC_W-1:0]  clamp_lim;
	logic signed [epid_pkg::INT_W-1:0]  clamp_set;
	logic signed [epid_pkg::MAC_W-1:0]  volts_full;
	logic signed [epid_pkg::VOLT_W-1:0] drive;
	logic [epid_pkg::BATT_W:0]          batt_rnd;

	assign s_tready = (state_q == epid_pkg::ST_IDLE);
	assign in_req   = s_tvalid && s_tready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= epid_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and step controls
	always_comb begin
		state_d      = state_q;
		mac_ctrl     = '0;
		mac_op       = epid_pkg::MOP_INTEG;
		div_start    = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			epid_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = epid_pkg::ST_DELTA;
			end
			epid_pkg::ST_DELTA: begin
				div_start = 1'b1;
				state_d   = epid_pkg::ST_ACC;
			end
			epid_pkg::ST_ACC:   state_d = epid_pkg::ST_ANGLE;
			epid_pkg::ST_ANGLE: state_d = epid_pkg::ST_ERR;
			epid_pkg::ST_ERR:   state_d = epid_pkg::ST_INTEG;
			epid_pkg::ST_INTEG: state_d = epid_pkg::ST_KI_LO;
			epid_pkg::ST_KI_LO: begin
				mac_ctrl.en    = 1'b1;
				mac_ctrl.clear = 1'b1;
				state_d        = epid_pkg::ST_KI_HI;
			end
			epid_pkg::ST_KI_HI: begin
				mac_ctrl.en = 1'b1;
				mac_ctrl.hi = 1'b1;
				state_d     = epid_pkg::ST_CLAMP;
			end
			epid_pkg::ST_CLAMP: state_d = epid_pkg::ST_KD_LO;
			epid_pkg::ST_KD_LO: begin
				mac_ctrl.en    = 1'b1;
				mac_ctrl.clear = 1'b1;
				mac_op         = epid_pkg::MOP_SPEED;
				state_d        = epid_pkg::ST_KD_HI;
			end
			epid_pkg::ST_KD_HI: begin
				mac_ctrl.en = 1'b1;
				mac_ctrl.hi = 1'b1;
				mac_op      = epid_pkg::MOP_SPEED;
				state_d     = epid_pkg::ST_KI2_LO;
			end
			epid_pkg::ST_KI2_LO: begin
				mac_ctrl.en = 1'b1;
				state_d     = epid_pkg::ST_KI2_HI;
			end
			epid_pkg::ST_KI2_HI: begin
				mac_ctrl.en = 1'b1;
				mac_ctrl.hi = 1'b1;
				state_d     = epid_pkg::ST_KP_LO;
			end
			epid_pkg::ST_KP_LO: begin
				mac_ctrl.en = 1'b1;
				mac_op      = epid_pkg::MOP_ERR;
				state_d     = epid_pkg::ST_KP_HI;
			end
			epid_pkg::ST_KP_HI: begin
				mac_ctrl.en = 1'b1;
				mac_ctrl.hi = 1'b1;
				mac_op      = epid_pkg::MOP_ERR;
				state_d     = epid_pkg::ST_SCALE;
			end
			epid_pkg::ST_SCALE: state_d = epid_pkg::ST_OUT;
			epid_pkg::ST_OUT: begin
				if ((!out_valid_q || m_tready) && !div_busy) begin
					out_load = 1'b1;
					state_d  = epid_pkg::ST_IDLE;
				end
			end
			default: state_d = epid_pkg::ST_IDLE;
		endcase
	end

	// operand and gain for the shared unit
	always_comb begin
		case (mac_op)
			epid_pkg::MOP_INTEG: begin
				mac_gain = ki_q;
				mac_opnd = integ_q;
			end
			epid_pkg::MOP_SPEED: begin
				mac_gain = kd_q;
				mac_opnd = epid_pkg::INT_W'(speed_q);
			end
			epid_pkg::MOP_ERR: begin
				mac_gain = kp_q;
				mac_opnd = epid_pkg::INT_W'(err_q);
			end
			default: begin
				mac_gain = '0;
				mac_opnd = '0;
			end
		endcase
	end

	epid_mac u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.gain (mac_gain),
		.opnd (mac_opnd),
		.acc  (mac_acc)
	);

	// battery filter numerator, divided by the constant denominator alongside
	assign batt_numer = epid_pkg::BATT_NUM_W'(batt_q) * epid_pkg::BATT_NUM_W'(epid_pkg::BATT_POLE)
		+ (epid_pkg::BATT_NUM_W'(mv_q) << epid_pkg::BATT_FRAC)
		+ epid_pkg::BATT_NUM_W'(epid_pkg::BATT_RND);

	epid_bdiv u_bdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (batt_numer),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	// angle in quarter counts, offset by half a turn
	assign angle_d = $signed({macc_q[epid_pkg::CNT_W-1], macc_q, 2'b00})
		- $signed(epid_pkg::ANG_W'(2 * epid_pkg::ENC_COUNTS));
	assign target9 = (epid_pkg::ANG_W'(target_q) <<< 3) + epid_pkg::ANG_W'(target_q);

	// saturating integral update
	assign integ_sum = (epid_pkg::INT_W + 1)'(integ_q) + (epid_pkg::INT_W + 1)'(err_q);
	always_comb begin
		if (integ_sum[epid_pkg::INT_W] != integ_sum[epid_pkg::INT_W-1]) begin
			integ_sat = integ_sum[epid_pkg::INT_W] ?
				$signed({1'b1, {(epid_pkg::INT_W-1){1'b0}}}) :
				$signed({1'b0, {(epid_pkg::INT_W-1){1'b1}}});
		end else begin
			integ_sat = integ_sum[epid_pkg::INT_W-1:0];
		end
	end

	// clamp threshold on gain times integral, and the value it is set to
	assign clamp_lim = $signed(epid_pkg::MAC_W'(lim_q)) <<< epid_pkg::LIM_SHIFT;
	assign clamp_set = $signed(epid_pkg::INT_W'(lim_q)) <<< epid_pkg::SET_SHIFT;

	// rounded shift to volts, saturation and enable
	assign volts_full = scaled_q >>> epid_pkg::ENC_SHIFT;
	always_comb begin
		if (volts_full > $signed(epid_pkg::MAC_W'(epid_pkg::VOLT_MAX))) begin
			drive = epid_pkg::VOLT_W'(epid_pkg::VOLT_MAX);
		end else if (volts_full < -$signed(epid_pkg::MAC_W'(epid_pkg::VOLT_MAX))) begin
			drive = -epid_pkg::VOLT_W'(epid_pkg::VOLT_MAX);
		end else begin
			drive = volts_full[epid_pkg::VOLT_W-1:0];
		end
		if (!en_q) drive = '0;
	end

	// battery rounded to whole millivolts
	assign batt_rnd = {1'b0, div_quot} + ((epid_pkg::BATT_W + 1)'(1) << (epid_pkg::BATT_FRAC - 1));

	// configuration and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q         <= epid_pkg::PROP_RESET;
			kd_q         <= epid_pkg::DERIV_RESET;
			ki_q         <= epid_pkg::INTEG_RESET;
			lim_q        <= epid_pkg::LIMIT_RESET;
			prev_mraw_q  <= '0;
			prev_sraw_q  <= '0;
			macc_q       <= '0;
			sacc_q       <= '0;
			target_q     <= epid_pkg::TGT_W'(epid_pkg::TARGET_RESET);
			prev_angle_q <= '0;
			integ_q      <= '0;
			batt_q       <= epid_pkg::BATT_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (epid_pkg::reg_idx_t'(cfg_idx))
					epid_pkg::REG_PROP_GAIN:   kp_q  <= cfg_wdata;
					epid_pkg::REG_DERIV_GAIN:  kd_q  <= cfg_wdata;
					epid_pkg::REG_INTEG_GAIN:  ki_q  <= cfg_wdata;
					epid_pkg::REG_INTEG_LIMIT: lim_q <= cfg_wdata;
					default: ;
				endcase
			end
			case (state_q)
				epid_pkg::ST_DELTA: begin
					prev_mraw_q <= mraw_q;
					prev_sraw_q <= sraw_q;
				end
				epid_pkg::ST_ACC: begin
					macc_q <= zero_q ? '0 : macc_q + epid_pkg::CNT_W'(dm_q);
					sacc_q <= zero_q ? '0 : sacc_q + epid_pkg::CNT_W'(ds_q);
					if (minus_q) begin
						target_q <= -epid_pkg::TGT_W'(epid_pkg::TARGET_PRESET);
					end else if (plus_q) begin
						target_q <= epid_pkg::TGT_W'(epid_pkg::TARGET_PRESET);
					end
				end
				epid_pkg::ST_ERR:   prev_angle_q <= angle_q;
				epid_pkg::ST_INTEG: integ_q <= integ_sat;
				epid_pkg::ST_CLAMP: begin
					if (ki_q != '0) begin
						if (mac_acc > clamp_lim) begin
							integ_q <= clamp_set;
						end else if (mac_acc < -clamp_lim) begin
							integ_q <= -clamp_set;
						end
					end
				end
				epid_pkg::ST_OUT: begin
					if (out_load) batt_q <= div_quot;
				end
				default: ;
			endcase
			// output register
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request capture and working values
	always_ff @(posedge clk) begin
		if (in_req) begin
			mraw_q  <= s_tdata[epid_pkg::IN_MRAW_LSB +: epid_pkg::RAW_W];
			sraw_q  <= s_tdata[epid_pkg::IN_SRAW_LSB +: epid_pkg::RAW_W];
			mv_q    <= s_tdata[epid_pkg::IN_MV_LSB +: epid_pkg::MV_W];
			zero_q  <= s_tdata[epid_pkg::IN_ZERO_BIT];
			plus_q  <= s_tdata[epid_pkg::IN_PLUS_BIT];
			minus_q <= s_tdata[epid_pkg::IN_MINUS_BIT];
			en_q    <= s_tdata[epid_pkg::IN_EN_BIT];
		end
		case (state_q)
			epid_pkg::ST_DELTA: begin
				dm_q <= unwrap(prev_mraw_q, mraw_q);
				ds_q <= unwrap(prev_sraw_q, sraw_q);
			end
			epid_pkg::ST_ANGLE: angle_q <= angle_d;
			epid_pkg::ST_ERR: begin
				err_q   <= target9 - angle_q;
				speed_q <= epid_pkg::SPD_W'(prev_angle_q) - epid_pkg::SPD_W'(angle_q);
			end
			epid_pkg::ST_SCALE: begin
				scaled_q <= mac_acc * $signed(epid_pkg::MAC_W'(epid_pkg::VOLT_SCALE))
					+ $signed(epid_pkg::MAC_W'(epid_pkg::ENC_HALF));
			end
			default: ;
		endcase
		if (out_load) begin
			out_data_q <= {sacc_q, macc_q, batt_rnd[epid_pkg::BATT_W-1:epid_pkg::BATT_FRAC],
				drive};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/epid_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module epid_mac (
	input  logic                                   clk,
	input  epid_pkg::mac_ctrl_t                    ctrl,
	input  logic        [epid_pkg::GAIN_W-1:0]     gain,
	input  logic signed [epid_pkg::INT_W-1:0]      opnd,
	output logic signed [epid_pkg::MAC_W-1:0]      acc
);

	logic signed [epid_pkg::GAIN_W:0]   mul_a;
	logic signed [epid_pkg::HALF_W:0]   mul_b;
	logic signed [epid_pkg::PROD_W-1:0] prod;
	logic signed [epid_pkg::MAC_W-1:0]  addend;
	logic signed [epid_pkg::MAC_W-1:0]  acc_q;

	// gain times one half of the operand, upper half signed
	assign mul_a = $signed({1'b0, gain});
	assign mul_b = ctrl.hi ?
		$signed({opnd[epid_pkg::INT_W-1], opnd[epid_pkg::INT_W-1:epid_pkg::HALF_W]}) :
		$signed({1'b0, opnd[epid_pkg::HALF_W-1:0]});
	assign prod  = mul_a * mul_b;

	// align upper partial product
	assign addend = ctrl.hi ? (epid_pkg::MAC_W'(prod) <<< epid_pkg::HALF_W) :
		epid_pkg::MAC_W'(prod);

	// accumulator
	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			acc_q <= ctrl.clear ? addend : acc_q + addend;
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

// ===== hw/rtl/epid_bdiv.sv =====
`timescale 1ns / 1ps
`default_nettype none

module epid_bdiv (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [epid_pkg::BATT_NUM_W-1:0]   numer,
	output logic                              busy,
	output logic [epid_pkg::BATT_W-1:0]       quot
);

	localparam int DIGIT     = 4;
	localparam int STEPS     = epid_pkg::BATT_NUM_W / DIGIT;
	localparam int STEP_W    = $clog2(STEPS);
	localparam int REM_W     = $clog2(epid_pkg::BATT_DEN);
	localparam logic [REM_W:0] DEN = (REM_W + 1)'(epid_pkg::BATT_DEN);
	localparam logic [STEP_W-1:0] LAST = STEP_W'(STEPS - 1);

	logic [epid_pkg::BATT_NUM_W-1:0] num_q;
	logic [REM_W-1:0]                rem_q;
	logic [STEP_W-1:0]               step_q;
	logic                            busy_q;
	logic [REM_W-1:0]                rem_d;
	logic [DIGIT-1:0]                qdig;

	// four restoring steps per cycle against the constant divisor
	always_comb begin
		logic [REM_W:0] trial;
		rem_d = rem_q;
		qdig  = '0;
		for (int i = 0; i < DIGIT; i++) begin
			trial = {rem_d, num_q[epid_pkg::BATT_NUM_W-1-i]};
			if (trial >= DEN) begin
				qdig[DIGIT-1-i] = 1'b1;
				rem_d = REM_W'(trial - DEN);
			end else begin
				rem_d = trial[REM_W-1:0];
			end
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	// numerator shifts out, quotient digits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[epid_pkg::BATT_NUM_W-DIGIT-1:0], qdig};
			rem_q <= rem_d;
		end
	end

	assign busy = busy_q;
	assign quot = num_q[epid_pkg::BATT_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/epid_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module epid_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [epid_pkg::OUT_W-1:0]  m_tdata
);

	// a waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// drive stays within the voltage limit
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[epid_pkg::VOLT_W-1:0]) <= epid_pkg::VOLT_MAX) &&
			($signed(m_tdata[epid_pkg::VOLT_W-1:0]) >= -epid_pkg::VOLT_MAX))
		else $error("drive voltage beyond limit");

	// one tick at a time
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken during a tick");

	// a new result only comes from a tick in progress
	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared while idle");

endmodule

bind encoder_pid_position_loop epid_checker u_epid_checker (.*);

`default_nettype wire

// ===== test/tb_encoder_pid_position_loop.sv =====
`timescale 1ns / 1ps

module tb_encoder_pid_position_loop;
	import epid_pkg::*;

	localparam longint INTEG48_MAX = (longint'(1) << 47) - 1;
	localparam longint INTEG48_MIN = -INTEG48_MAX - 1;
	localparam int     PHASES      = 8;
	localparam int     PHASE_TICKS = 205;

	typedef struct packed {
		logic [RAW_W-1:0] motor_raw;
		logic [RAW_W-1:0] steer_raw;
		logic [MV_W-1:0]  battery_mv;
		logic             zero_counts;
		logic             preset_plus;
		logic             preset_minus;
		logic             enable;
	} tick_t;

	typedef struct packed {
		logic [VOLT_W-1:0] drive_voltage;
		logic [MV_W-1:0]   battery_filtered_mv;
		logic [CNT_W-1:0]  motor_count;
		logic [CNT_W-1:0]  steer_count;
	} loop_out_t;

	// block ports, all inputs known from time zero
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [OUT_W-1:0]     m_tdata;
	logic                 cfg_wen   = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx   = '0;
	logic [GAIN_W-1:0]    cfg_wdata = '0;

	// loop state as the block should hold it
	longint           kp          = longint'(PROP_RESET);
	longint           kd          = longint'(DERIV_RESET);
	longint           ki          = longint'(INTEG_RESET);
	longint           klim        = longint'(LIMIT_RESET);
	logic [RAW_W-1:0] prev_motor  = '0;
	logic [RAW_W-1:0] prev_steer  = '0;
	logic [CNT_W-1:0] motor_total = '0;
	logic [CNT_W-1:0] steer_total = '0;
	longint           aim         = TARGET_RESET;
	longint           last_angle4 = 0;
	longint           integ       = 0;
	logic [BATT_W-1:0] batt_q16   = BATT_RESET;

	// shadow of the motor position used to steer the stimulus
	logic [RAW_W-1:0] gen_raw = '0;
	longint           gen_acc = 0;
	longint           gen_aim = TARGET_RESET;

	tick_t     pending_ticks[$];
	tick_t     sent_tick;
	loop_out_t expected_outs[$];
	bit        sender_busy;
	bit        no_idle;
	int        send_gap;
	int        take_gap;
	int        ticks_sent;
	int        results_checked;
	int        mismatch_count;

	encoder_pid_position_loop DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// encoder step is previous minus new, folded into half a turn
	function automatic longint encoder_step(logic [RAW_W-1:0] was, logic [RAW_W-1:0] now);
		longint d;
		d = longint'(was) - longint'(now);
		if (d > ENC_HALF)
			d -= ENC_COUNTS;
		else if (d < -ENC_HALF)
			d += ENC_COUNTS;
		return d;
	endfunction

	// one control tick of the position loop
	function automatic loop_out_t step_position_loop(tick_t t);
		longint    batt_next, step_m, step_s, angle4, err4, speed4;
		longint    thr, setv, sum, volts;
		loop_out_t r;
		// battery smoothing
		batt_next = (longint'(batt_q16) * BATT_POLE + (longint'(t.battery_mv) << BATT_FRAC)
			+ BATT_RND) / BATT_DEN;
		batt_q16 = 32'(batt_next);
		// unwrap and accumulate both encoders
		step_m = encoder_step(prev_motor, t.motor_raw);
		step_s = encoder_step(prev_steer, t.steer_raw);
		prev_motor = t.motor_raw;
		prev_steer = t.steer_raw;
		motor_total = motor_total + 32'(step_m);
		steer_total = steer_total + 32'(step_s);
		if (t.zero_counts) begin
			motor_total = '0;
			steer_total = '0;
		end
		// presets, minus wins
		if (t.preset_plus)
			aim = TARGET_PRESET;
		if (t.preset_minus)
			aim = -TARGET_PRESET;
		// loop terms in quarter counts
		angle4 = 4 * longint'($signed(motor_total)) - 2 * ENC_COUNTS;
		err4 = 9 * aim - angle4;
		speed4 = last_angle4 - angle4;
		last_angle4 = angle4;
		// integral with 48-bit saturation, then the clamp
		integ = integ + err4;
		if (integ > INTEG48_MAX)
			integ = INTEG48_MAX;
		else if (integ < INTEG48_MIN)
			integ = INTEG48_MIN;
		if (ki != 0) begin
			thr = (4 * klim * ENC_COUNTS) / ki;
			setv = (klim * ENC_COUNTS) / 64;
			if (integ > thr)
				integ = setv;
			else if (-integ > thr)
				integ = -setv;
		end
		// drive, rounded, floored and saturated
		sum = kd * speed4 + ki * integ + kp * err4;
		volts = (VOLT_SCALE * sum + ENC_HALF) >>> ENC_SHIFT;
		if (volts > VOLT_MAX)
			volts = VOLT_MAX;
		else if (volts < -VOLT_MAX)
			volts = -VOLT_MAX;
		if (!t.enable)
			volts = 0;
		r.drive_voltage = 16'(volts);
		r.battery_filtered_mv = 16'((longint'(batt_q16) + 32768) >> BATT_FRAC);
		r.motor_count = motor_total;
		r.steer_count = steer_total;
		return r;
	endfunction

	function automatic int pick_gap();
		if (no_idle)
			return 0;
		return $urandom_range(0, 14);
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// compare one result with the oldest outstanding tick
	task automatic check_result(logic [OUT_W-1:0] word);
		loop_out_t want;
		loop_out_t got;
		if (expected_outs.size() == 0) begin
			report_mismatch("result with no tick outstanding");
			return;
		end
		want = expected_outs.pop_front();
		got.drive_voltage = word[0 +: VOLT_W];
		got.battery_filtered_mv = word[VOLT_W +: MV_W];
		got.motor_count = word[VOLT_W + MV_W +: CNT_W];
		got.steer_count = word[VOLT_W + MV_W + CNT_W +: CNT_W];
		results_checked++;
		if (got.drive_voltage !== want.drive_voltage)
			report_mismatch($sformatf("result %0d drive_voltage %0d, want %0d", results_checked,
				$signed(got.drive_voltage), $signed(want.drive_voltage)));
		if (got.battery_filtered_mv !== want.battery_filtered_mv)
			report_mismatch($sformatf("result %0d battery_filtered_mv %0d, want %0d",
				results_checked, got.battery_filtered_mv, want.battery_filtered_mv));
		if (got.motor_count !== want.motor_count)
			report_mismatch($sformatf("result %0d motor_count %0d, want %0d", results_checked,
				$signed(got.motor_count), $signed(want.motor_count)));
		if (got.steer_count !== want.steer_count)
			report_mismatch($sformatf("result %0d steer_count %0d, want %0d", results_checked,
				$signed(got.steer_count), $signed(want.steer_count)));
	endtask

	// request driver: predicts on acceptance, then waits its gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			sender_busy = 1'b0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_outs.push_back(step_position_loop(sent_tick));
				ticks_sent++;
				sender_busy = 1'b0;
				send_gap = pick_gap();
			end
			if (!sender_busy) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_ticks.size() > 0) begin
					sent_tick = pending_ticks.pop_front();
					s_tdata <= {sent_tick.enable, sent_tick.preset_minus, sent_tick.preset_plus,
						sent_tick.zero_counts, sent_tick.battery_mv, sent_tick.steer_raw,
						sent_tick.motor_raw};
					sender_busy = 1'b1;
				end
			end
			s_tvalid <= sender_busy;
		end
	end

	// result monitor with random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			take_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_result(m_tdata);
				take_gap = pick_gap();
			end
			if (take_gap > 0) begin
				take_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic tick_t make_tick(int m, int s, int mv, bit zero, bit plus, bit minus,
		bit en);
		tick_t t;
		t.motor_raw = RAW_W'(m);
		t.steer_raw = RAW_W'(s);
		t.battery_mv = MV_W'(mv);
		t.zero_counts = zero;
		t.preset_plus = plus;
		t.preset_minus = minus;
		t.enable = en;
		return t;
	endfunction

	// queue a tick and keep the stimulus shadow in step
	task automatic queue_tick(tick_t t);
		gen_acc += encoder_step(gen_raw, t.motor_raw);
		gen_raw = t.motor_raw;
		if (t.zero_counts)
			gen_acc = 0;
		if (t.preset_plus)
			gen_aim = TARGET_PRESET;
		if (t.preset_minus)
			gen_aim = -TARGET_PRESET;
		pending_ticks.push_back(t);
	endtask

	// mostly a motor that chases its target, with jumps and noise mixed in
	function automatic tick_t random_tick();
		tick_t  t;
		int     pick;
		longint goal, move;
		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			goal = (9 * gen_aim) / 4 + ENC_HALF;
			move = (goal - gen_acc) / longint'($urandom_range(1, 4))
				+ longint'($urandom_range(0, 256)) - 128;
			if (move > 8000)
				move = 8000;
			else if (move < -8000)
				move = -8000;
			t.motor_raw = RAW_W'(longint'(gen_raw) - move);
		end else if (pick < 92) begin
			move = longint'($urandom_range(0, ENC_COUNTS)) - ENC_HALF;
			t.motor_raw = RAW_W'(longint'(gen_raw) - move);
		end else begin
			t.motor_raw = RAW_W'($urandom);
		end
		if ($urandom_range(0, 1))
			t.steer_raw = RAW_W'(longint'(prev_steer_hint) + longint'($urandom_range(0, 100)) - 50);
		else
			t.steer_raw = RAW_W'($urandom);
		prev_steer_hint = t.steer_raw;
		if ($urandom_range(0, 9) < 7)
			t.battery_mv = MV_W'(22000 + $urandom_range(0, 4000));
		else
			t.battery_mv = MV_W'($urandom);
		t.zero_counts = ($urandom_range(0, 39) == 0);
		t.preset_plus = ($urandom_range(0, 11) == 0);
		t.preset_minus = ($urandom_range(0, 11) == 0);
		t.enable = ($urandom_range(0, 9) != 0);
		return t;
	endfunction

	logic [RAW_W-1:0] prev_steer_hint = '0;

	// configuration only while nothing is in flight
	task automatic write_reg(reg_idx_t idx, logic [GAIN_W-1:0] value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_PROP_GAIN: begin
				kp = value;
			end
			REG_DERIV_GAIN: begin
				kd = value;
			end
			REG_INTEG_GAIN: begin
				ki = value;
			end
			REG_INTEG_LIMIT: begin
				klim = value;
			end
			default: begin
			end
		endcase
	endtask

	task automatic wait_idle();
		while (pending_ticks.size() != 0 || sender_busy || expected_outs.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// reset, directed ticks, then gain phases of random ticks
	initial begin
		int               phase;
		int               n;
		logic [GAIN_W-1:0] w_kp, w_kd, w_ki, w_lim;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: half-turn steps both ways, wrap of the raw reading, flags
		queue_tick(make_tick(0, 0, 0, 0, 0, 0, 1));
		queue_tick(make_tick(8192, 8192, 65535, 0, 0, 0, 1));
		queue_tick(make_tick(0, 0, 65535, 0, 0, 0, 1));
		queue_tick(make_tick(16383, 16383, 65535, 0, 0, 0, 1));
		queue_tick(make_tick(0, 0, 24000, 0, 0, 0, 1));
		queue_tick(make_tick(8193, 8191, 24000, 0, 0, 0, 1));
		queue_tick(make_tick(1, 16383, 12000, 0, 0, 0, 1));
		queue_tick(make_tick(16383, 16383, 0, 1, 0, 0, 1));
		queue_tick(make_tick(16000, 300, 24000, 0, 1, 0, 1));
		queue_tick(make_tick(15000, 600, 24000, 0, 0, 1, 1));
		queue_tick(make_tick(14000, 900, 24000, 0, 1, 1, 1));
		queue_tick(make_tick(6000, 9000, 30000, 0, 0, 0, 0));
		queue_tick(make_tick(16383, 16383, 65535, 1, 1, 1, 1));
		queue_tick(make_tick(0, 0, 0, 0, 0, 0, 0));
		queue_tick(make_tick('h2AAA, 'h1555, 'hAAAA, 0, 1, 0, 1));
		queue_tick(make_tick('h1555, 'h2AAA, 'h5555, 0, 0, 1, 1));
		queue_tick(make_tick(8192, 0, 24000, 0, 0, 0, 1));

		for (phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				wait_idle();
				case (phase)
					1: begin
						w_kp = '1; w_kd = '1; w_ki = '1; w_lim = '1;
					end
					2: begin
						w_kp = '0; w_kd = '0; w_ki = '0; w_lim = '0;
					end
					3: begin
						w_kp = PROP_RESET; w_kd = DERIV_RESET; w_ki = 16'd256; w_lim = 16'd256;
					end
					4: begin
						w_kp = 16'd1024; w_kd = 16'd0; w_ki = '1; w_lim = '0;
					end
					5: begin
						w_kp = 16'd256; w_kd = 16'd512; w_ki = 16'd1; w_lim = '1;
					end
					6: begin
						w_kp = $urandom; w_kd = $urandom; w_ki = $urandom; w_lim = $urandom;
					end
					default: begin
						w_kp = $urandom_range(0, 2047); w_kd = $urandom_range(0, 4095);
						w_ki = $urandom_range(1, 255); w_lim = $urandom_range(0, 1023);
					end
				endcase
				write_reg(REG_PROP_GAIN, w_kp);
				write_reg(REG_DERIV_GAIN, w_kd);
				write_reg(REG_INTEG_GAIN, w_ki);
				write_reg(REG_INTEG_LIMIT, w_lim);
			end
			// one phase runs back to back on both sides
			no_idle = (phase == 2);
			for (n = 0; n < PHASE_TICKS; n++) begin
				queue_tick(random_tick());
				// sender holds off mid-phase until every result is back
				if (phase == 5 && n == PHASE_TICKS / 2)
					wait_idle();
			end
		end

		wait_idle();
		repeat (40) @(posedge clk);
		$display("ran %0d control ticks across %0d gain settings with random stalls",
			ticks_sent, PHASES);
		$display("%0d results compared, %0d mismatches", results_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/epid_pkg.sv
hw/rtl/epid_mac.sv
hw/rtl/epid_bdiv.sv
hw/rtl/encoder_pid_position_loop.sv
hw/rtl/epid_checker.sv
test/tb_encoder_pid_position_loop.sv
